// ===== rtl/core/rxc_pkg.sv =====
// Shared types, constants and byte-transform functions of the rotate-XOR chained byte cipher.
// No dependencies; the top, rxc_step, rxc_outq and the testbench import this package.
package rxc_pkg;

    localparam logic [7:0] CHAIN_START = 8'd77;
    localparam logic [2:0] ROT_LAST    = 3'd6;   // rotate phase runs 0..6

    localparam int KEY_W   = 64;
    localparam int CFG_W   = KEY_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 2'd2;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] chain_byte;
        logic [2:0] rotate_phase;
        logic [2:0] key_phase;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_result;

    typedef struct packed {
        t_state     st;
        logic [7:0] val;
    } t_byte_step;

    // Everything one accepted request produces: up to two results and the next state.
    typedef struct packed {
        t_state     next_state;
        t_result    res0;
        t_result    res1;
        logic [1:0] num;
    } t_step_out;

    localparam t_state STATE_START = '{chain_byte: CHAIN_START, rotate_phase: 3'd0,
                                       key_phase: 3'd0};

    function automatic logic [7:0] rot_right(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w = {v, v} >> n;
        return w[7:0];
    endfunction

    function automatic logic [7:0] rot_left(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w = {v, v} << n;
        return w[15:8];
    endfunction

    // Key byte 0 is the most significant byte.
    function automatic logic [7:0] key_at(input logic [KEY_W-1:0] key, input logic [2:0] k);
        logic [2:0] idx;
        idx = 3'd7 - k;
        return key[{idx, 3'b000} +: 8];
    endfunction

    function automatic t_state advance(input t_state s, input logic [7:0] c);
        t_state r;
        r.chain_byte   = c;
        r.rotate_phase = (s.rotate_phase == ROT_LAST) ? 3'd0 : s.rotate_phase + 3'd1;
        r.key_phase    = s.key_phase + 3'd1;
        return r;
    endfunction

    function automatic t_byte_step enc_byte(input t_state s, input logic [7:0] b,
                                            input logic [KEY_W-1:0] key);
        t_byte_step r;
        r.val = rot_right(b, s.rotate_phase + 3'd1) ^ s.chain_byte ^ key_at(key, s.key_phase);
        r.st  = advance(s, r.val);
        return r;
    endfunction

    function automatic t_byte_step dec_byte(input t_state s, input logic [7:0] c,
                                            input logic [KEY_W-1:0] key);
        t_byte_step r;
        r.val = rot_left(c ^ s.chain_byte ^ key_at(key, s.key_phase), s.rotate_phase + 3'd1);
        r.st  = advance(s, c);
        return r;
    endfunction

endpackage

// ===== rtl/core/rxc_in_if.sv =====
// Input channel of the cipher: valid/ready handshake and one message byte with its framing flags.
// No dependencies.
interface rxc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic       carries_byte;

    modport source (output valid, data_byte, first, last, carries_byte, input ready);
    modport sink   (input valid, data_byte, first, last, carries_byte, output ready);
endinterface

// ===== rtl/core/rxc_out_if.sv =====
// Output channel of the cipher: valid/ready handshake and one result byte with its flags.
// No dependencies.
interface rxc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, out_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, out_byte, has_byte, end_of_message, output ready);
endinterface

// ===== rtl/core/rotate_xor_chain_byte_cipher_top.sv =====
// A result is written to the result queue when its request is accepted and offered from there.
// Throughput: one request per cycle while the four-entry result queue has at least two free
// entries; the output side delivers one result per cycle while the receiver is ready, so an
// encrypt request that opens a message and carries a byte hands its two results out in turn.
// Reset (synchronous, active low): queue empties, chain restarts at 77, phases and registers 0.
// Depends on rxc_pkg, rxc_in_if, rxc_out_if, rxc_step and rxc_outq.
module rotate_xor_chain_byte_cipher_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rxc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rxc_pkg::CFG_W-1:0]           i_cfg_data,
    rxc_in_if.sink                              i_in,
    rxc_out_if.source                           o_out
);
    import rxc_pkg::*;

    // Configuration registers. They must only be written while no request is in flight; the block does not enforce it.
    logic [KEY_W-1:0] r_key;
    logic             r_mode;
    logic [7:0]       r_prefix;

    // Chain state carried from one request to the next.
    t_state           r_state;

    t_step_out        step;
    t_result          head;
    logic             accept;
    logic             q_room;
    logic             q_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_mode   <= MODE_ENC;
            r_prefix <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY:    r_key    <= i_cfg_data;
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_PREFIX: r_prefix <= i_cfg_data[7:0];
                default:    ;  // index past the register list: write is dropped
            endcase
        end
    end

    // The whole byte transform is a rotate and two XORs per byte, so it sits between the
    // accepted request and the queue entries. The encrypt-first case chains two of them.
    rxc_step u_step (
        .i_state        (r_state),
        .i_key          (r_key),
        .i_mode         (r_mode),
        .i_prefix       (r_prefix),
        .i_data_byte    (i_in.data_byte),
        .i_first        (i_in.first),
        .i_last         (i_in.last),
        .i_carries_byte (i_in.carries_byte),
        .o_step         (step)
    );

    assign i_in.ready = q_room;
    assign accept     = i_in.valid && q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_START;
        end else if (accept) begin
            r_state <= step.next_state;
        end
    end

    // The queue decouples the two sides: new requests keep coming while results wait, as long as it has room.
    rxc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_num  (accept ? step.num : 2'd0),
        .i_res0      (step.res0),
        .i_res1      (step.res1),
        .i_pop       (o_out.ready),
        .o_head      (head),
        .o_not_empty (q_not_empty),
        .o_room      (q_room)
    );

    assign o_out.valid          = q_not_empty;
    assign o_out.out_byte       = head.out_byte;
    assign o_out.has_byte       = head.has_byte;
    assign o_out.end_of_message = head.end_of_message;

endmodule

// ===== rtl/core/rxc_step.sv =====
// Combinational transform of one request: prefix handling, encrypt or decrypt, next chain state.
// Depends on rxc_pkg.
module rxc_step (
    input  rxc_pkg::t_state             i_state,
    input  logic [rxc_pkg::KEY_W-1:0]   i_key,
    input  logic                        i_mode,
    input  logic [7:0]                  i_prefix,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_first,
    input  logic                        i_last,
    input  logic                        i_carries_byte,
    output rxc_pkg::t_step_out          o_step
);
    import rxc_pkg::*;

    t_state     st0;
    t_byte_step e0;
    t_byte_step e1;
    t_byte_step d0;
    t_result    closing;

    assign st0 = i_first ? STATE_START : i_state;
    // The first encrypted byte is the prefix on a first request, else the carried byte.
    assign e0  = enc_byte(st0, i_first ? i_prefix : i_data_byte, i_key);
    assign e1  = enc_byte(e0.st, i_data_byte, i_key);
    assign d0  = dec_byte(st0, i_data_byte, i_key);
    assign closing = '{out_byte: 8'd0, has_byte: 1'b0, end_of_message: 1'b1};

    always_comb begin
        o_step.next_state = st0;
        o_step.res0       = closing;
        o_step.res1       = closing;
        o_step.num        = 2'd0;
        if (i_mode == MODE_ENC) begin
            if (i_first) begin
                o_step.res0 = '{out_byte: e0.val, has_byte: 1'b1,
                                end_of_message: !i_carries_byte && i_last};
                o_step.next_state = e0.st;
                o_step.num = 2'd1;
                if (i_carries_byte) begin
                    o_step.res1 = '{out_byte: e1.val, has_byte: 1'b1, end_of_message: i_last};
                    o_step.next_state = e1.st;
                    o_step.num = 2'd2;
                end
            end else if (i_carries_byte) begin
                o_step.res0 = '{out_byte: e0.val, has_byte: 1'b1, end_of_message: i_last};
                o_step.next_state = e0.st;
                o_step.num = 2'd1;
            end else if (i_last) begin
                o_step.num = 2'd1;
            end
        end else begin
            if (i_carries_byte) begin
                o_step.next_state = d0.st;
                if (!i_first) begin
                    o_step.res0 = '{out_byte: d0.val, has_byte: 1'b1, end_of_message: i_last};
                    o_step.num = 2'd1;
                end else if (i_last) begin
                    o_step.num = 2'd1;
                end
            end else if (i_last) begin
                o_step.num = 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/rxc_outq.sv =====
// Result queue of the cipher: takes up to two results a cycle, hands out one a cycle when popped.
// Depends on rxc_pkg.
module rxc_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_push_num,
    input  rxc_pkg::t_result                i_res0,
    input  rxc_pkg::t_result                i_res1,
    input  logic                            i_pop,
    output rxc_pkg::t_result                o_head,
    output logic                            o_not_empty,
    output logic                            o_room
);
    import rxc_pkg::*;

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr;
    logic [OUTQ_PTR_W-1:0]  r_rd;
    logic [OUTQ_CNT_W-1:0]  r_count;
    logic [OUTQ_PTR_W-1:0]  n_wr;
    logic [OUTQ_PTR_W-1:0]  n_rd;
    logic [OUTQ_CNT_W-1:0]  n_count;
    logic                   do_pop;

    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd];
    // Room for a two-result request, whatever the consumer does this cycle.
    assign o_room      = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wr    = r_wr + OUTQ_PTR_W'(i_push_num);
        n_rd    = r_rd + OUTQ_PTR_W'(do_pop);
        n_count = r_count + OUTQ_CNT_W'(i_push_num) - OUTQ_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_num == 2'd2) begin
            r_mem[r_wr + OUTQ_PTR_W'(1)] <= i_res1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue count beyond depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_num != 2'd0) |-> (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2)))
        else $error("push into result queue without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && i_push_num == 2'd0) |=> (r_count == $past(r_count) - OUTQ_CNT_W'(1)))
        else $error("result queue count wrong after pop");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == OUTQ_PTR_W'(r_count))
        else $error("result queue pointers disagree with count");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the rotate-XOR chained byte cipher: drives framed byte requests,
// predicts results with its own model or typed table entries, checks them in order of arrival.
// Depends on rxc_pkg, rxc_in_if, rxc_out_if and rotate_xor_chain_byte_cipher_top.
module tb;
    import rxc_pkg::*;

    // Index 3 fits the two-bit register index but names no register, so a write to it
    // must leave every register as it was.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int ROT_SPAN      = 7;    // rotate amount repeats every seven positions
    localparam int KEY_BYTES     = 8;    // key byte index repeats every eight positions
    localparam int SETTLE_CYCLES = 4;    // margin for results still in flight
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       carries;
    } t_byte_req;

    typedef enum {ROW_REQ, ROW_CFG} t_row_kind;

    // One row of the directed table: either a register write or a request. A request row
    // either carries the results typed in by hand (typed set) or defers to the predictor.
    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_W-1:0]         value;
        t_byte_req                req;
        bit                       typed;
        int                       n;
        t_result                  res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    rxc_in_if  req_ch ();
    rxc_out_if res_ch ();

    rotate_xor_chain_byte_cipher_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch),
        .o_out      (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the chaining state.
    logic [CFG_W-1:0] key_reg    = '0;
    logic             mode_reg   = MODE_ENC;
    logic [7:0]       prefix_reg = '0;
    logic [7:0]       chain_q    = CHAIN_START;
    int               rot_pos    = 0;
    int               key_pos    = 0;

    t_result   awaited_results[$];
    t_dir_row  dir_rows[$];

    int error_count   = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Key byte 0 sits in the top eight bits of the key.
    function automatic logic [7:0] key_byte(input int k);
        return key_reg[CFG_W-1-8*k -: 8];
    endfunction

    function automatic logic [7:0] ror_by(input logic [7:0] v, input int n);
        return (v >> n) | (v << (8 - n));
    endfunction

    function automatic logic [7:0] rol_by(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic void step_positions();
        rot_pos = (rot_pos + 1) % ROT_SPAN;
        key_pos = (key_pos + 1) % KEY_BYTES;
    endfunction

    function automatic logic [7:0] enc_step(input logic [7:0] plain);
        logic [7:0] c;
        c = ror_by(plain, rot_pos + 1) ^ chain_q ^ key_byte(key_pos);
        chain_q = c;
        step_positions();
        return c;
    endfunction

    // The chain follows the ciphertext, so it takes the incoming byte, not the decoded one.
    function automatic logic [7:0] dec_step(input logic [7:0] cipher);
        logic [7:0] p;
        int         amount;
        p       = cipher ^ chain_q ^ key_byte(key_pos);
        amount  = rot_pos + 1;
        chain_q = cipher;
        step_positions();
        return rol_by(p, amount);
    endfunction

    function automatic t_result make_result(input logic [7:0] b, input logic has,
                                            input logic eom);
        t_result r;
        r.out_byte       = b;
        r.has_byte       = has;
        r.end_of_message = eom;
        return r;
    endfunction

    // Works out the results of one accepted request and advances the predictor state.
    function automatic int cipher_step(input t_byte_req r, output t_result o0,
                                       output t_result o1);
        int         n;
        logic [7:0] p;
        n  = 0;
        o0 = '0;
        o1 = '0;
        if (r.first) begin
            chain_q = CHAIN_START;
            rot_pos = 0;
            key_pos = 0;
        end
        if (mode_reg == MODE_ENC) begin
            if (r.first) begin
                // The prefix goes out first; it only ends the message when nothing follows.
                o0 = make_result(enc_step(prefix_reg), 1'b1, r.last && !r.carries);
                n  = 1;
                if (r.carries) begin
                    o1 = make_result(enc_step(r.data), 1'b1, r.last);
                    n  = 2;
                end
            end else if (r.carries) begin
                o0 = make_result(enc_step(r.data), 1'b1, r.last);
                n  = 1;
            end else if (r.last) begin
                o0 = make_result(8'h00, 1'b0, 1'b1);
                n  = 1;
            end
        end else begin
            if (r.carries) begin
                // A first byte is the prefix: it feeds the chain but is never delivered.
                p = dec_step(r.data);
                if (!r.first) begin
                    o0 = make_result(p, 1'b1, r.last);
                    n  = 1;
                end else if (r.last) begin
                    o0 = make_result(8'h00, 1'b0, 1'b1);
                    n  = 1;
                end
            end else if (r.last) begin
                o0 = make_result(8'h00, 1'b0, 1'b1);
                n  = 1;
            end
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Results are sampled at the rising edge, before any nonblocking update of that edge,
    // and compared against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("arrived with nothing expected", int'(res_ch.out_byte), 0);
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(res_ch.out_byte), int'(want.out_byte));
                if (res_ch.has_byte !== want.has_byte)
                    report_mismatch("has_byte", int'(res_ch.has_byte), int'(want.has_byte));
                if (res_ch.end_of_message !== want.end_of_message)
                    report_mismatch("end_of_message", int'(res_ch.end_of_message),
                                    int'(want.end_of_message));
            end
            results_seen++;
        end
    end

    // The receiver stalls at random; the rate is set per phase by the main sequence.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one request, holds it until the block takes it, then records what it should
    // produce. Valid is left high on return so that a request that follows at once keeps
    // the channel busy; the next call lowers it only when it decides to idle.
    task automatic send_request(input t_byte_req r, input bit typed, input int n_typed,
                                input t_result typed_res);
        t_result p0;
        t_result p1;
        int      n;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.data_byte    <= r.data;
        req_ch.first        <= r.first;
        req_ch.last         <= r.last;
        req_ch.carries_byte <= r.carries;
        do @(posedge i_clk); while (!req_ch.ready);
        // The predictor always runs so its state stays in step; a typed row then
        // replaces the expectation with the value written into the table.
        n = cipher_step(r, p0, p1);
        if (typed) begin
            n  = n_typed;
            p0 = typed_res;
        end
        if (n > 0) awaited_results.push_back(p0);
        if (n > 1) awaited_results.push_back(p1);
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has come, plus a short margin
    // for requests that produce nothing but may still be in flight.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable drops for one cycle after each write, so back-to-back writes never
    // schedule two updates of it at the same edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_KEY:    key_reg    = value;
            REG_MODE:   mode_reg   = value[0];
            REG_PREFIX: prefix_reg = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Mostly well-formed messages of random content, short as a rule with an occasional
    // long one; the rest are lone random requests and messages that never close.
    task automatic send_message();
        int        roll;
        int        len;
        bit        broken;
        t_byte_req r;
        roll = $urandom_range(99);
        if (roll < 10) begin
            r.data    = 8'($urandom_range(255));
            r.first   = 1'($urandom_range(1));
            r.last    = 1'($urandom_range(1));
            r.carries = 1'($urandom_range(1));
            send_request(r, 1'b0, 0, '0);
            return;
        end
        broken = (roll < 16);
        len    = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        if (len == 0) begin
            r.data    = 8'($urandom_range(255));
            r.first   = 1'b1;
            r.last    = !broken;
            r.carries = 1'b0;
            send_request(r, 1'b0, 0, '0);
        end else begin
            for (int i = 0; i < len; i++) begin
                r.data    = 8'($urandom_range(255));
                r.first   = (i == 0);
                r.last    = (i == len - 1) && !broken;
                r.carries = 1'b1;
                send_request(r, 1'b0, 0, '0);
            end
        end
    endtask

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] value);
        t_dir_row row;
        row       = '{kind: ROW_CFG, default: '0};
        row.idx   = idx;
        row.value = value;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [7:0] d, input bit f, input bit l,
                                      input bit c, input int n, input t_result res);
        t_dir_row row;
        row       = '{kind: ROW_REQ, default: '0};
        row.req   = '{data: d, first: f, last: l, carries: c};
        row.typed = 1'b1;
        row.n     = n;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_req(input logic [7:0] d, input bit f, input bit l,
                                    input bit c);
        add_typed(d, f, l, c, 0, '0);
        dir_rows[$].typed = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_result no_res;
        t_result closing;
        int      phase_start;
        bit      paused;
        int      idle_mode;
        logic [CFG_W-1:0] key_val;
        logic [7:0]       prefix_val;

        no_res  = '0;
        closing = make_result(8'h00, 1'b0, 1'b1);

        // Every input is known from time zero, while reset is held.
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= REG_KEY;
        i_cfg_data          <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.data_byte    <= '0;
        req_ch.first        <= 1'b0;
        req_ch.last         <= 1'b0;
        req_ch.carries_byte <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. With the reset key and prefix of zero, an empty encrypt message
        // yields just the encrypted prefix, which is the chain start itself.
        add_typed(8'h00, 1'b1, 1'b1, 1'b0, 1, make_result(8'd77, 1'b1, 1'b1));
        // No byte, not first: a close when last is set, otherwise nothing at all.
        add_typed(8'h00, 1'b0, 1'b1, 1'b0, 1, closing);
        add_typed(8'h5A, 1'b0, 1'b0, 1'b0, 0, no_res);
        // First request with a byte gives two results: prefix, then the byte.
        add_req(8'hFF, 1'b1, 1'b0, 1'b1);
        add_req(8'h00, 1'b0, 1'b0, 1'b1);
        add_req(8'h80, 1'b0, 1'b1, 1'b1);
        // A prefix that does not end the message, closed later by an empty last request.
        add_req(8'h3C, 1'b1, 1'b0, 1'b0);
        add_typed(8'h00, 1'b0, 1'b1, 1'b0, 1, closing);
        // All-ones extremes, then a ten-position message so both phases wrap.
        add_cfg(REG_KEY, '1);
        add_cfg(REG_PREFIX, 64'hFF);
        add_req(8'hFF, 1'b1, 1'b1, 1'b1);
        add_req(8'hAA, 1'b1, 1'b0, 1'b1);
        for (int k = 0; k < 8; k++)
            add_req(8'h01 << k, 1'b0, (k == 7), 1'b1);
        // Decrypt: the first byte is swallowed; alone in its message it leaves just a close.
        add_cfg(REG_MODE, {{(CFG_W-1){1'b0}}, MODE_DEC});
        add_typed(8'hFF, 1'b1, 1'b1, 1'b1, 1, closing);
        add_typed(8'h55, 1'b1, 1'b0, 1'b1, 0, no_res);
        add_req(8'h12, 1'b0, 1'b0, 1'b1);
        add_typed(8'h00, 1'b0, 1'b1, 1'b0, 1, closing);
        // Decrypt first without a byte restarts the chain and feeds nothing into it.
        add_typed(8'h00, 1'b1, 1'b1, 1'b0, 1, closing);
        add_typed(8'h00, 1'b1, 1'b0, 1'b0, 0, no_res);
        add_req(8'hFF, 1'b0, 1'b1, 1'b1);
        // A write to the unused index must not disturb the mode or any other register.
        add_cfg(REG_UNUSED, '1);
        add_req(8'h00, 1'b0, 1'b1, 1'b1);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].n,
                             dir_rows[i].res);
            end
        end

        // Random phases. The first eight pair both modes with each idling profile; the
        // rest pick the profile at random. Key and prefix extremes land in both modes.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            idle_mode = (ph < 8) ? (ph / 2) % 4 : $urandom_range(3);
            case (idle_mode)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            key_val    = (ph == 2) ? '1 : (ph == 5) ? '0 : {$urandom, $urandom};
            prefix_val = 8'((ph == 3) ? 8'hFF : (ph == 6) ? 8'h00 : $urandom_range(255));
            write_reg(REG_KEY, key_val);
            write_reg(REG_MODE, CFG_W'((ph % 2 == 0) ? MODE_ENC : MODE_DEC));
            write_reg(REG_PREFIX, CFG_W'(prefix_val));

            phase_start = items_sent;
            paused      = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // Halfway through each phase the sender holds off until the output drains.
                if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
                send_message();
            end
        end

        // Final drain with a bound; anything still outstanding afterwards never arrived.
        req_ch.valid <= 1'b0;
        for (int w = 0; w < 1000 && awaited_results.size() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        foreach (awaited_results[i])
            report_mismatch("never delivered", 0, int'(awaited_results[i].out_byte));

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: a run that has not finished by its time limit is ended and reported as failed.
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
